### rtl/tcrq_pkg.sv
package tcrq_pkg;

  // Default queue depth
  localparam int unsigned QUEUE_DEPTH = 32;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [0:0] REG_SCHED_POLICY = 1'b0;

  // Input function codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Scheduling policy codes
  localparam logic [1:0] POL_ARRIVAL = 2'd0;
  localparam logic [1:0] POL_CLASS0  = 2'd1;
  localparam logic [1:0] POL_CLASS1  = 2'd2;

  // One stored request
  typedef struct packed {
    logic        cls;
    logic [15:0] conn;
    logic [15:0] name;
    logic [31:0] stamp;
  } entry_t;

  // One input transaction
  typedef struct packed {
    logic        func;
    logic        cls;
    logic [15:0] conn;
    logic [15:0] name;
    logic [31:0] stamp;
  } req_t;

  // One result transaction
  typedef struct packed {
    logic        accepted;
    logic        rejected_full;
    logic        served_valid;
    logic        served_class;
    logic [15:0] served_conn;
    logic [15:0] served_name;
    logic [31:0] served_arrival;
    logic [5:0]  occupancy;
  } res_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_KEY,
    ST_RD,
    ST_CMP,
    ST_DEQ,
    ST_RESP
  } state_e;

  // Unknown policy codes order by arrival stamp
  function automatic logic [1:0] eff_policy(input logic [1:0] p);
    logic [1:0] r;
    r = POL_ARRIVAL;
    if (p == POL_CLASS0 || p == POL_CLASS1) begin
      r = p;
    end
    return r;
  endfunction

  // Strict ordering: a goes before b under policy p
  function automatic logic key_less(input entry_t a, input entry_t b, input logic [1:0] p);
    logic r;
    case (eff_policy(p))
      POL_CLASS0: r = !a.cls && b.cls;
      POL_CLASS1: r = a.cls && !b.cls;
      default:    r = a.stamp < b.stamp;
    endcase
    return r;
  endfunction

endpackage

### rtl/tcrq_req_if.sv
interface tcrq_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic        req_class;
  logic [15:0] conn_id;
  logic [15:0] name_ref;
  logic [31:0] arrival_time;

  modport source (
    output valid, func, req_class, conn_id, name_ref, arrival_time,
    input  ready
  );
  modport sink (
    input  valid, func, req_class, conn_id, name_ref, arrival_time,
    output ready
  );
endinterface

### rtl/tcrq_res_if.sv
interface tcrq_res_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        rejected_full;
  logic        served_valid;
  logic        served_class;
  logic [15:0] served_conn;
  logic [15:0] served_name;
  logic [31:0] served_arrival;
  logic [5:0]  occupancy;

  modport source (
    output valid, accepted, rejected_full, served_valid, served_class,
           served_conn, served_name, served_arrival, occupancy,
    input  ready
  );
  modport sink (
    input  valid, accepted, rejected_full, served_valid, served_class,
           served_conn, served_name, served_arrival, occupancy,
    output ready
  );
endinterface

### rtl/two_class_request_queue_unit.sv
// Two-class request queue.
// req_i carries enqueue (func 0) and dequeue (func 1) transactions; every
// transaction gives exactly one result transaction on res_o, in order.
// The APB port holds sched_policy at byte address 0; an enqueue latches it
// and reorders the queue by arrival stamp, oldest first, or by class.
// Entries live in one ring memory with a registered read; the
// sequencer runs an insertion sort through its single read and write port.
// A dequeue reads the head entry and passes it to the result. An enqueue
// under an unchanged policy moves only the new entry toward the head;
// after a policy change it sorts the whole queue. A full-queue reject or
// an empty dequeue goes straight to the result.
// One transaction is in work at a time; req_i.ready is high only while idle.
// The result waits in an output register, so a stalled res_o still lets the
// next transaction be accepted and worked up to its result.
// Reset empties the queue and sets the policy to arrival order; memory
// contents need no clearing.
module two_class_request_queue_unit #(
  parameter int unsigned QueueDepth = tcrq_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tcrq_req_if.sink                        req_i,
  tcrq_res_if.source                      res_o,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [tcrq_pkg::CFG_ADDR_W-1:0] paddr_i,
  input  logic [31:0]                     pwdata_i,
  output logic [31:0]                     prdata_o,
  output logic                            pready_o
);

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  logic             ready;
  logic             out_valid;
  logic [1:0]       sched_policy;
  tcrq_pkg::req_t   req;
  tcrq_pkg::res_t   res;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [AddrW-1:0] ram_raddr;
  tcrq_pkg::entry_t ram_wdata;
  tcrq_pkg::entry_t ram_rdata;

  assign req = '{func: req_i.func, cls: req_i.req_class, conn: req_i.conn_id,
                 name: req_i.name_ref, stamp: req_i.arrival_time};

  // Configuration registers
  tcrq_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel_i),
    .penable_i      (penable_i),
    .pwrite_i       (pwrite_i),
    .paddr_i        (paddr_i),
    .pwdata_i       (pwdata_i),
    .prdata_o       (prdata_o),
    .pready_o       (pready_o),
    .sched_policy_o (sched_policy)
  );

  // Sequencer and result register
  tcrq_ctrl #(
    .Depth (QueueDepth),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (ready),
    .in_req_i       (req),
    .sched_policy_i (sched_policy),
    .out_valid_o    (out_valid),
    .out_ready_i    (res_o.ready),
    .out_res_o      (res),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  // Entry storage
  tcrq_ram #(
    .Depth (QueueDepth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready          = ready;
  assign res_o.valid          = out_valid;
  assign res_o.accepted       = res.accepted;
  assign res_o.rejected_full  = res.rejected_full;
  assign res_o.served_valid   = res.served_valid;
  assign res_o.served_class   = res.served_class;
  assign res_o.served_conn    = res.served_conn;
  assign res_o.served_name    = res.served_name;
  assign res_o.served_arrival = res.served_arrival;
  assign res_o.occupancy      = res.occupancy;

endmodule

### rtl/tcrq_cfg.sv
module tcrq_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [tcrq_pkg::CFG_ADDR_W-1:0] paddr_i,
  input  logic [31:0]                     pwdata_i,
  output logic [31:0]                     prdata_o,
  output logic                            pready_o,
  output logic [1:0]                      sched_policy_o
);

  logic [1:0] sched_q, sched_d;
  logic       hit;

  // Word index sits above the byte offset
  assign hit = (paddr_i[2] == tcrq_pkg::REG_SCHED_POLICY);

  always_comb begin
    sched_d = sched_q;
    if (psel_i && penable_i && pwrite_i && hit) begin
      sched_d = pwdata_i[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_q <= tcrq_pkg::POL_ARRIVAL;
    end else begin
      sched_q <= sched_d;
    end
  end

  // Read back; unmapped words read zero
  assign prdata_o       = hit ? {30'b0, sched_q} : 32'b0;
  assign pready_o       = 1'b1;
  assign sched_policy_o = sched_q;

endmodule

### rtl/tcrq_ram.sv
module tcrq_ram #(
  parameter int unsigned Depth = tcrq_pkg::QUEUE_DEPTH,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  tcrq_pkg::entry_t    wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output tcrq_pkg::entry_t    rdata_o
);

  tcrq_pkg::entry_t mem [Depth];
  tcrq_pkg::entry_t rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tcrq_ctrl.sv
module tcrq_ctrl #(
  parameter int unsigned Depth = tcrq_pkg::QUEUE_DEPTH,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcrq_pkg::req_t      in_req_i,
  input  logic [1:0]          sched_policy_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcrq_pkg::res_t      out_res_o,
  output logic                ram_we_o,
  output logic [AddrW-1:0]    ram_waddr_o,
  output tcrq_pkg::entry_t    ram_wdata_o,
  output logic [AddrW-1:0]    ram_raddr_o,
  input  tcrq_pkg::entry_t    ram_rdata_i
);

  tcrq_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [1:0]       applied_q, applied_d;
  logic [CntW-1:0]  i_q, i_d;
  logic [CntW-1:0]  j_q, j_d;
  tcrq_pkg::entry_t key_q, key_d;
  tcrq_pkg::res_t   res_q, res_d;
  tcrq_pkg::res_t   out_q, out_d;
  logic             out_valid_q, out_valid_d;
  tcrq_pkg::entry_t new_entry;

  // Queue position to ring address
  function automatic logic [AddrW-1:0] phys(input logic [AddrW-1:0] head,
                                            input logic [CntW-1:0] l);
    logic [CntW:0] s;
    s = (CntW+1)'(head) + (CntW+1)'(l);
    if (s >= (CntW+1)'(Depth)) begin
      s = s - (CntW+1)'(Depth);
    end
    return s[AddrW-1:0];
  endfunction

  // Count shown on six bits
  function automatic logic [5:0] occ(input logic [CntW-1:0] c);
    logic [CntW+5:0] w;
    w = {6'b0, c};
    return w[5:0];
  endfunction

  assign new_entry = '{cls: in_req_i.cls, conn: in_req_i.conn,
                       name: in_req_i.name, stamp: in_req_i.stamp};

  // Sequencer: enqueue runs an insertion sort over the ring in memory.
  // A read whose data is used never hits the entry written in the same step, so no forwarding.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    applied_d   = applied_q;
    i_d         = i_q;
    j_d         = j_q;
    key_d       = key_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = phys(head_q, count_q);
    ram_wdata_o = new_entry;
    ram_raddr_o = head_q;

    case (state_q)
      tcrq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d = '0;
          if (in_req_i.func == tcrq_pkg::FUNC_DEQ) begin
            if (count_q == '0) begin
              state_d = tcrq_pkg::ST_RESP;
            end else begin
              state_d = tcrq_pkg::ST_DEQ;
            end
          end else if (count_q == CntW'(Depth)) begin
            res_d.rejected_full = 1'b1;
            res_d.occupancy     = occ(count_q);
            state_d             = tcrq_pkg::ST_RESP;
          end else begin
            // Append at the tail, then sort
            ram_we_o  = 1'b1;
            count_d   = count_q + CntW'(1);
            applied_d = sched_policy_i;
            // Already ordered under the same key: only the new tail moves
            if (tcrq_pkg::eff_policy(applied_q) == tcrq_pkg::eff_policy(sched_policy_i)) begin
              i_d = count_q;
            end else begin
              i_d = CntW'(1);
            end
            state_d = tcrq_pkg::ST_NEXT;
          end
        end
      end

      tcrq_pkg::ST_NEXT: begin
        if (i_q >= count_q) begin
          res_d.accepted  = 1'b1;
          res_d.occupancy = occ(count_q);
          state_d         = tcrq_pkg::ST_RESP;
        end else begin
          ram_raddr_o = phys(head_q, i_q);
          state_d     = tcrq_pkg::ST_KEY;
        end
      end

      tcrq_pkg::ST_KEY: begin
        key_d   = ram_rdata_i;
        j_d     = i_q;
        state_d = tcrq_pkg::ST_RD;
      end

      tcrq_pkg::ST_RD: begin
        if (j_q == '0) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = head_q;
          ram_wdata_o = key_q;
          i_d         = i_q + CntW'(1);
          state_d     = tcrq_pkg::ST_NEXT;
        end else begin
          ram_raddr_o = phys(head_q, j_q - CntW'(1));
          state_d     = tcrq_pkg::ST_CMP;
        end
      end

      tcrq_pkg::ST_CMP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = phys(head_q, j_q);
        if (tcrq_pkg::key_less(key_q, ram_rdata_i, applied_q)) begin
          // Shift the neighbor up one place
          ram_wdata_o = ram_rdata_i;
          j_d         = j_q - CntW'(1);
          state_d     = tcrq_pkg::ST_RD;
        end else begin
          ram_wdata_o = key_q;
          i_d         = i_q + CntW'(1);
          state_d     = tcrq_pkg::ST_NEXT;
        end
      end

      tcrq_pkg::ST_DEQ: begin
        res_d.served_valid   = 1'b1;
        res_d.served_class   = ram_rdata_i.cls;
        res_d.served_conn    = ram_rdata_i.conn;
        res_d.served_name    = ram_rdata_i.name;
        res_d.served_arrival = ram_rdata_i.stamp;
        res_d.occupancy      = occ(count_q - CntW'(1));
        count_d              = count_q - CntW'(1);
        head_d               = phys(head_q, CntW'(1));
        state_d              = tcrq_pkg::ST_RESP;
      end

      tcrq_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = tcrq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tcrq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcrq_pkg::ST_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      applied_q   <= tcrq_pkg::POL_ARRIVAL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      applied_q   <= applied_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    key_q <= key_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

### rtl/tcrq_checker.sv
module tcrq_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        accepted_i,
  input logic        rejected_full_i,
  input logic        served_valid_i,
  input logic [15:0] served_conn_i,
  input logic [31:0] served_arrival_i,
  input logic [5:0]  occupancy_i
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(served_arrival_i))
    else $error("result changed while stalled");

  // One transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

  // At most one outcome flag per result
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0({accepted_i, rejected_full_i, served_valid_i}))
    else $error("conflicting result flags");

  // No served payload without a served entry
  a_served_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !served_valid_i |-> served_conn_i == 16'd0 && served_arrival_i == 32'd0)
    else $error("served fields set without a served entry");

  // A dequeue on an empty queue reports it empty
  a_empty_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !served_valid_i && !accepted_i && !rejected_full_i |-> occupancy_i == 6'd0)
    else $error("empty dequeue with nonzero occupancy");

endmodule

bind two_class_request_queue_unit tcrq_props u_tcrq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .accepted_i       (res_o.accepted),
  .rejected_full_i  (res_o.rejected_full),
  .served_valid_i   (res_o.served_valid),
  .served_conn_i    (res_o.served_conn),
  .served_arrival_i (res_o.served_arrival),
  .occupancy_i      (res_o.occupancy)
);

### sim/tcrq_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the APB port, predicts every result transaction
// and compares it field by field with the one the queue returns.
module tcrq_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tcrq_req_if                             req_i,
  tcrq_res_if                             res_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [tcrq_pkg::CFG_ADDR_W-1:0] paddr_i,
  input  logic [31:0]                     pwdata_i,
  input  logic                            pready_i,
  output int unsigned                     fail_cnt_o,
  output int unsigned                     outstanding_o
);

  localparam logic [tcrq_pkg::CFG_ADDR_W-1:0] POLICY_ADDR =
    tcrq_pkg::CFG_ADDR_W'(4 * tcrq_pkg::REG_SCHED_POLICY);

  // Shadow of the queue contents, head at index 0
  tcrq_pkg::entry_t held [tcrq_pkg::QUEUE_DEPTH];
  int unsigned      held_n;
  logic [1:0]       cur_policy;
  tcrq_pkg::res_t   due_results [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_cnt_o++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", what, got, want));
    end
  endtask

  // Stable reorder: entries of class lead_cls move ahead of the others
  function automatic void group_by_class(input logic lead_cls);
    tcrq_pkg::entry_t tmp [tcrq_pkg::QUEUE_DEPTH];
    int unsigned      k;
    k = 0;
    for (int unsigned i = 0; i < held_n; i++) begin
      if (held[i].cls == lead_cls) begin
        tmp[k] = held[i];
        k++;
      end
    end
    for (int unsigned i = 0; i < held_n; i++) begin
      if (held[i].cls != lead_cls) begin
        tmp[k] = held[i];
        k++;
      end
    end
    for (int unsigned i = 0; i < held_n; i++) begin
      held[i] = tmp[i];
    end
  endfunction

  // Apply one request transaction to the shadow queue, return its result
  function automatic tcrq_pkg::res_t queue_outcome(input tcrq_pkg::req_t r);
    tcrq_pkg::res_t   o;
    tcrq_pkg::entry_t key;
    int unsigned      j;
    o = '0;
    if (r.func == tcrq_pkg::FUNC_ENQ) begin
      if (held_n >= tcrq_pkg::QUEUE_DEPTH) begin
        o.rejected_full = 1'b1;
      end else begin
        key.cls   = r.cls;
        key.conn  = r.conn;
        key.name  = r.name;
        key.stamp = r.stamp;
        held[held_n] = key;
        held_n++;
        case (cur_policy)
          tcrq_pkg::POL_CLASS0: group_by_class(1'b0);
          tcrq_pkg::POL_CLASS1: group_by_class(1'b1);
          default: begin
            // stable insertion sort, oldest stamp first
            for (int unsigned i = 1; i < held_n; i++) begin
              key = held[i];
              j = i;
              while (j > 0 && key.stamp < held[j-1].stamp) begin
                held[j] = held[j-1];
                j--;
              end
              held[j] = key;
            end
          end
        endcase
        o.accepted = 1'b1;
      end
    end else if (held_n != 0) begin
      o.served_valid   = 1'b1;
      o.served_class   = held[0].cls;
      o.served_conn    = held[0].conn;
      o.served_name    = held[0].name;
      o.served_arrival = held[0].stamp;
      for (int unsigned i = 1; i < held_n; i++) begin
        held[i-1] = held[i];
      end
      held_n--;
    end
    o.occupancy = 6'(held_n);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    tcrq_pkg::req_t r;
    tcrq_pkg::res_t want;
    if (!rst_ni) begin
      held_n = 0;
      cur_policy = tcrq_pkg::POL_ARRIVAL;
      due_results.delete();
      fail_cnt_o = 0;
      outstanding_o <= 0;
    end else begin
      // register write
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == POLICY_ADDR) begin
        cur_policy = pwdata_i[1:0];
      end

      // result transaction: compare against the oldest prediction
      if (res_i.valid && res_i.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          want = due_results.pop_front();
          check_field("accepted", 32'(res_i.accepted), 32'(want.accepted));
          check_field("rejected_full", 32'(res_i.rejected_full), 32'(want.rejected_full));
          check_field("served_valid", 32'(res_i.served_valid), 32'(want.served_valid));
          check_field("served_class", 32'(res_i.served_class), 32'(want.served_class));
          check_field("served_conn", 32'(res_i.served_conn), 32'(want.served_conn));
          check_field("served_name", 32'(res_i.served_name), 32'(want.served_name));
          check_field("served_arrival", res_i.served_arrival, want.served_arrival);
          check_field("occupancy", 32'(res_i.occupancy), 32'(want.occupancy));
        end
      end

      // request transaction: predict its result
      if (req_i.valid && req_i.ready) begin
        r.func  = req_i.func;
        r.cls   = req_i.req_class;
        r.conn  = req_i.conn_id;
        r.name  = req_i.name_ref;
        r.stamp = req_i.arrival_time;
        due_results.push_back(queue_outcome(r));
      end

      outstanding_o <= due_results.size();
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [tcrq_pkg::CFG_ADDR_W-1:0] POLICY_ADDR =
    tcrq_pkg::CFG_ADDR_W'(4 * tcrq_pkg::REG_SCHED_POLICY);
  localparam logic [1:0] POL_SPARE   = 2'd3;
  localparam int         HOLD_CYCLES = 400;
  localparam int         STALL_LIMIT = 5000;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            psel_i;
  logic                            penable_i;
  logic                            pwrite_i;
  logic [tcrq_pkg::CFG_ADDR_W-1:0] paddr_i;
  logic [31:0]                     pwdata_i;
  logic [31:0]                     prdata_o;
  logic                            pready_o;
  int unsigned                     fail_cnt;
  int unsigned                     outstanding;
  int                              tx_idle_pct;
  int                              rx_idle_pct;
  logic                            hold_go;
  int                              quiet_cycles;
  logic [1:0]                      policy_pool [4];

  tcrq_req_if req_bus ();
  tcrq_res_if res_bus ();

  two_class_request_queue_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_bus),
    .res_o     (res_bus),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  tcrq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_bus),
    .res_i         (res_bus),
    .psel_i        (psel_i),
    .penable_i     (penable_i),
    .pwrite_i      (pwrite_i),
    .paddr_i       (paddr_i),
    .pwdata_i      (pwdata_i),
    .pready_i      (pready_o),
    .fail_cnt_o    (fail_cnt),
    .outstanding_o (outstanding)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Result side: random stalls, plus one long hold-off to back up the queue
  initial begin : receiver
    logic hold_taken;
    hold_taken = 1'b0;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("two_class_request_queue_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request transaction and wait until it is taken
  task automatic put_req(input logic f, input logic c, input logic [15:0] cn,
                         input logic [15:0] nm, input logic [31:0] st);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.func         <= f;
    req_bus.req_class    <= c;
    req_bus.conn_id      <= cn;
    req_bus.name_ref     <= nm;
    req_bus.arrival_time <= st;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of the scheduling policy, only with the queue idle
  task automatic apply_policy(input logic [1:0] pol);
    drain();
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= POLICY_ADDR;
    pwdata_i  <= {30'd0, pol};
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  // Random mix: a fill stretch that tends to hit full, then a drain stretch
  task automatic run_chunk(input int fill_n, input int total_n);
    logic [31:0] st;
    for (int i = 0; i < total_n; i++) begin
      st = $urandom_range(1) ? $urandom : $urandom_range(7);
      if ($urandom_range(99) < ((i < fill_n) ? 92 : 10)) begin
        put_req(tcrq_pkg::FUNC_ENQ, 1'($urandom_range(1)), 16'($urandom),
                16'($urandom), st);
      end else begin
        put_req(tcrq_pkg::FUNC_DEQ, 1'($urandom_range(1)), 16'($urandom),
                16'($urandom), st);
      end
    end
  endtask

  initial begin : stimulus
    policy_pool = '{tcrq_pkg::POL_ARRIVAL, tcrq_pkg::POL_CLASS0,
                    tcrq_pkg::POL_CLASS1, POL_SPARE};
    rst_ni               = 1'b0;
    psel_i               = 1'b0;
    penable_i            = 1'b0;
    pwrite_i             = 1'b0;
    paddr_i              = '0;
    pwdata_i             = '0;
    req_bus.valid        = 1'b0;
    req_bus.func         = tcrq_pkg::FUNC_ENQ;
    req_bus.req_class    = 1'b0;
    req_bus.conn_id      = '0;
    req_bus.name_ref     = '0;
    req_bus.arrival_time = '0;
    hold_go              = 1'b0;
    tx_idle_pct          = 25;
    rx_idle_pct          = 78;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // arrival order: empty dequeue, extreme fields, equal stamps keep order
    apply_policy(tcrq_pkg::POL_ARRIVAL);
    put_req(tcrq_pkg::FUNC_DEQ, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    put_req(tcrq_pkg::FUNC_ENQ, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    put_req(tcrq_pkg::FUNC_ENQ, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000);
    put_req(tcrq_pkg::FUNC_ENQ, 1'b1, 16'h1234, 16'hABCD, 32'h0000_0000);
    repeat (4) put_req(tcrq_pkg::FUNC_DEQ, 1'b0, 16'h0000, 16'h0000, 32'h0);

    // class zero first, then switch to class one first with entries held
    apply_policy(tcrq_pkg::POL_CLASS0);
    for (int i = 0; i < 4; i++) begin
      put_req(tcrq_pkg::FUNC_ENQ, ~i[0], 16'(i), 16'(100 + i), 32'(100 - i));
    end
    apply_policy(tcrq_pkg::POL_CLASS1);
    put_req(tcrq_pkg::FUNC_ENQ, 1'b0, 16'h00AA, 16'h00BB, 32'd50);
    repeat (5) put_req(tcrq_pkg::FUNC_DEQ, 1'b0, 16'h0000, 16'h0000, 32'h0);

    // unused policy code falls back to arrival order
    apply_policy(POL_SPARE);
    put_req(tcrq_pkg::FUNC_ENQ, 1'b1, 16'h0001, 16'h0002, 32'd5);
    put_req(tcrq_pkg::FUNC_ENQ, 1'b0, 16'h0003, 16'h0004, 32'd3);
    put_req(tcrq_pkg::FUNC_ENQ, 1'b1, 16'h0005, 16'h0006, 32'd5);
    repeat (3) put_req(tcrq_pkg::FUNC_DEQ, 1'b0, 16'h0000, 16'h0000, 32'h0);

    // random phases: sender mostly busy, then receiver mostly busy, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 78 : 0;
      rx_idle_pct <= (ph == 0) ? 78 : (ph == 1) ? 25 : 0;
      for (int k = 0; k < 3; k++) begin
        apply_policy(policy_pool[$urandom_range(3)]);
        run_chunk($urandom_range(40, 20), 60);
      end
    end

    // long result stall while requests keep coming, then empty the queue
    apply_policy(tcrq_pkg::POL_CLASS1);
    hold_go <= 1'b1;
    run_chunk(30, 30);
    run_chunk(0, 40);

    drain();
    repeat (16) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("two_class_request_queue_unit verification clean");
    end else begin
      $display("two_class_request_queue_unit verification failed");
    end
    $finish;
  end

endmodule
